/* sv/bbc_pkg.sv */
// Shared types, character codes and helpers for the bracket balance checker.
`default_nettype none

package bbc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_COMMENT = 8'hE3;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        K_PAREN,
        K_BRACK,
        K_BRACE
    } t_kind;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_DQ,
        M_DQ_ESC,
        M_SQ,
        M_SQ_QUOTE,
        M_COMMENT
    } t_mode;

    typedef enum logic [2:0] {
        V_OK,
        V_UNMATCHED,
        V_MISMATCH,
        V_TOO_DEEP,
        V_UNCLOSED_BR,
        V_UNCLOSED_QT,
        V_STOP
    } t_verdict;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        t_verdict    verdict;
        logic [7:0]  offending_byte;
        logic [15:0] byte_position;
        logic        top_semicolon_seen;
    } t_out_beat;

    // Stack control from the scanner: depth is the depth before this op.
    typedef struct packed {
        logic               push;
        logic               pop;
        t_kind              kind;
        logic [DEPTH_W-1:0] depth;
    } t_stack_op;

    function automatic logic [7:0] open_char(input t_kind k);
        logic [7:0] c;
        case (k)
            K_PAREN: c = CH_LPAREN;
            K_BRACK: c = CH_LBRACK;
            default: c = CH_LBRACE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/bbc_stack.sv */
// Bracket-kind stack: memory plus registered top and prefetched next-below entry.
`default_nettype none

module bbc_stack
    import bbc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_stack_op i_op,
    output t_kind          o_top,
    output t_kind          o_below
);

    t_kind             r_mem [STACK_DEPTH];
    t_kind             r_top;
    t_kind             r_below;
    logic [ADDR_W-1:0] rd_addr;

    // Prefetch the entry two below the next depth, so a pop finds its new top ready.
    always_comb begin
        if (i_op.push) begin
            rd_addr = i_op.depth[ADDR_W-1:0] - ADDR_W'(1);
        end else if (i_op.pop) begin
            rd_addr = i_op.depth[ADDR_W-1:0] - ADDR_W'(3);
        end else begin
            rd_addr = i_op.depth[ADDR_W-1:0] - ADDR_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_mem[i_op.depth[ADDR_W-1:0]] <= i_op.kind;
        end
        r_below <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_top <= i_op.kind;
        end else if (i_op.pop) begin
            r_top <= r_below;
        end
    end

    assign o_top   = r_top;
    assign o_below = r_below;

endmodule

`default_nettype wire

/* sv/bbc_scan.sv */
// Lexical scanner and verdict logic, one byte per cycle while i_fire is high.
`default_nettype none

module bbc_scan
    import bbc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_beat  i_beat,
    input  wire logic      i_stop_mode,
    input  wire t_kind     i_top,
    input  wire t_kind     i_below,
    output t_stack_op      o_op,
    output logic           o_res_valid,
    output t_out_beat      o_res
);

    t_mode              r_mode,  n_mode;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_semi,  n_semi;
    logic [15:0]        r_pos,   n_pos;
    logic               r_disc,  n_disc;

    logic       run_normal;
    logic       is_open;
    logic       is_close;
    t_kind      bkind;
    t_kind      top_after;
    logic [7:0] b;
    logic       fin;

    assign b   = i_beat.text_byte;
    assign fin = i_beat.final_byte;

    always_comb begin
        is_open  = 1'b0;
        is_close = 1'b0;
        bkind    = K_PAREN;
        case (b)
            CH_LPAREN: begin is_open  = 1'b1; bkind = K_PAREN; end
            CH_LBRACK: begin is_open  = 1'b1; bkind = K_BRACK; end
            CH_LBRACE: begin is_open  = 1'b1; bkind = K_BRACE; end
            CH_RPAREN: begin is_close = 1'b1; bkind = K_PAREN; end
            CH_RBRACK: begin is_close = 1'b1; bkind = K_BRACK; end
            CH_RBRACE: begin is_close = 1'b1; bkind = K_BRACE; end
            default: ;
        endcase
    end

    always_comb begin
        n_mode      = r_mode;
        n_depth     = r_depth;
        n_semi      = r_semi;
        n_pos       = r_pos;
        n_disc      = r_disc;
        run_normal  = 1'b0;
        top_after   = i_top;
        o_op        = '{push: 1'b0, pop: 1'b0, kind: bkind, depth: r_depth};
        o_res_valid = 1'b0;
        o_res       = '{verdict: V_OK, offending_byte: 8'h00, byte_position: r_pos,
                        top_semicolon_seen: 1'b0};
        if (i_fire) begin
            if (r_disc) begin
                if (fin) begin
                    n_mode  = M_NORMAL;
                    n_depth = '0;
                    n_semi  = 1'b0;
                    n_pos   = '0;
                    n_disc  = 1'b0;
                end
            end else begin
                case (r_mode)
                    M_DQ: begin
                        if (b == CH_BSLASH) begin
                            n_mode = M_DQ_ESC;
                        end else if (b == CH_DQUOTE) begin
                            n_mode = M_NORMAL;
                        end
                    end
                    M_DQ_ESC: begin
                        n_mode = M_DQ;
                    end
                    M_SQ: begin
                        if (b == CH_SQUOTE) begin
                            n_mode = M_SQ_QUOTE;
                        end
                    end
                    M_SQ_QUOTE: begin
                        if (b == CH_SQUOTE) begin
                            n_mode = M_SQ;
                        end else begin
                            n_mode     = M_NORMAL;
                            run_normal = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (b == CH_NEWLINE) begin
                            n_mode = M_NORMAL;
                        end
                    end
                    default: begin
                        n_mode     = M_NORMAL;
                        run_normal = 1'b1;
                    end
                endcase

                if (run_normal) begin
                    if (b == CH_DQUOTE) begin
                        n_mode = M_DQ;
                    end else if (b == CH_SQUOTE) begin
                        n_mode = M_SQ;
                    end else if (b == CH_COMMENT) begin
                        n_mode = M_COMMENT;
                    end else if (b == CH_SEMI) begin
                        if (r_depth == '0) begin
                            if (i_stop_mode) begin
                                o_res_valid          = 1'b1;
                                o_res.verdict        = V_STOP;
                                o_res.offending_byte = b;
                            end else begin
                                n_semi = 1'b1;
                            end
                        end
                    end else if (is_close) begin
                        if (r_depth == '0) begin
                            o_res_valid          = 1'b1;
                            o_res.verdict        = i_stop_mode ? V_STOP : V_UNMATCHED;
                            o_res.offending_byte = b;
                        end else begin
                            n_depth   = r_depth - DEPTH_W'(1);
                            o_op.pop  = 1'b1;
                            top_after = i_below;
                            if (i_top != bkind) begin
                                o_res_valid          = 1'b1;
                                o_res.verdict        = V_MISMATCH;
                                o_res.offending_byte = open_char(i_top);
                            end
                        end
                    end else if (is_open) begin
                        if (r_depth == DEPTH_W'(STACK_DEPTH)) begin
                            o_res_valid          = 1'b1;
                            o_res.verdict        = V_TOO_DEEP;
                            o_res.offending_byte = b;
                        end else begin
                            n_depth   = r_depth + DEPTH_W'(1);
                            o_op.push = 1'b1;
                            top_after = bkind;
                        end
                    end
                end

                // End of string: open quote wins over open brackets
                if (!o_res_valid && fin) begin
                    o_res_valid = 1'b1;
                    if (n_mode == M_DQ || n_mode == M_DQ_ESC) begin
                        o_res.verdict        = V_UNCLOSED_QT;
                        o_res.offending_byte = CH_DQUOTE;
                    end else if (n_mode == M_SQ) begin
                        o_res.verdict        = V_UNCLOSED_QT;
                        o_res.offending_byte = CH_SQUOTE;
                    end else if (n_depth != '0) begin
                        o_res.verdict        = V_UNCLOSED_BR;
                        o_res.offending_byte = open_char(top_after);
                    end else begin
                        o_res.verdict        = V_OK;
                        o_res.offending_byte = 8'h00;
                    end
                end

                o_res.top_semicolon_seen = n_semi;

                if (!o_res_valid) begin
                    if (r_pos != 16'hFFFF) begin
                        n_pos = r_pos + 16'd1;
                    end
                end else if (fin) begin
                    n_mode  = M_NORMAL;
                    n_depth = '0;
                    n_semi  = 1'b0;
                    n_pos   = '0;
                    n_disc  = 1'b0;
                end else begin
                    n_disc = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_depth <= '0;
            r_semi  <= 1'b0;
            r_pos   <= '0;
            r_disc  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_semi  <= n_semi;
            r_pos   <= n_pos;
            r_disc  <= n_disc;
        end
    end

endmodule

`default_nettype wire

/* sv/bracket_balance_checker.sv */
// Top level of the bracket balance checker: input and result registers around the scanner.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries one text byte per beat,
//   with final_byte marking the last byte of a string. Output channel (o_out_valid /
//   i_out_stall / o_out_beat) carries at most one verdict per string.
//   Configuration: i_cfg_we with i_cfg_wdata writes stop_mode; write only while idle.
// Path: an accepted byte waits in the input register until the result register can
//   take a beat; it is then scanned and its verdict, if any, registered for output.
// Throughput: one byte per cycle while the output is not stalled. The stack top sits in
//   a register and the entry below it is prefetched from the stack memory each cycle,
//   so push and pop never hold the scanner.
// Reset: synchronous, active low. Clears the scan state, the beat valids and
//   stop_mode. The stack memory is not cleared; only entries pushed in the
//   current string ever affect a verdict.
// Stall: while the result register holds a beat and i_out_stall is high, the
//   scanner holds and o_in_stall rises once the input register is also full.
//   The input register is refilled in the same cycle the held byte moves on.
`default_nettype none

module bracket_balance_checker
    import bbc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_wdata
);

    logic      r_in_valid;
    t_in_beat  r_in_beat;
    logic      r_out_valid;
    t_out_beat r_out_beat;
    logic      r_stop_mode;

    logic      advance;
    logic      in_take;
    t_stack_op stk_op;
    t_kind     stk_top;
    t_kind     stk_below;
    logic      res_valid;
    t_out_beat res;

    // Scanner moves the held byte whenever the result register can take a beat
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_beat <= i_in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_stop_mode <= i_cfg_wdata;
        end
    end

    bbc_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_beat      (r_in_beat),
        .i_stop_mode (r_stop_mode),
        .i_top       (stk_top),
        .i_below     (stk_below),
        .o_op        (stk_op),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bbc_stack u_stack (
        .i_clk   (i_clk),
        .i_op    (stk_op),
        .o_top   (stk_top),
        .o_below (stk_below)
    );

    // Result register: valid follows every scanned byte, the beat loads on a verdict, drains when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_beat <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

`default_nettype wire

/* sv/bbc_checker.sv */
// Port-level assertions for the bracket balance checker, bound to the top level.
`default_nettype none

module bbc_checker
    import bbc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_beat
);

    a_reset_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled result beat changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    a_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.verdict == V_OK |-> o_out_beat.offending_byte == 8'h00)
        else $error("ok verdict with nonzero offending byte");

    a_close_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.verdict == V_UNMATCHED |->
            o_out_beat.offending_byte == CH_RPAREN ||
            o_out_beat.offending_byte == CH_RBRACK ||
            o_out_beat.offending_byte == CH_RBRACE)
        else $error("unmatched close reports a non-close byte");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);

`default_nettype wire

/* tb/sv/bbc_verdict_monitor.sv */
`timescale 1ns / 1ps
// Channel monitor for the bracket balance checker: predicts each verdict and compares it.
module bbc_verdict_monitor
    import bbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_beat   i_in_beat,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_beat  i_out_beat,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output logic [7:0] o_kinds_seen
);

    localparam int MAX_PRINTS = 64;
    localparam logic [2:0][7:0] OPENER = {CH_LBRACE, CH_LBRACK, CH_LPAREN};

    // Predicted scanner state
    t_kind       kind_stack [STACK_DEPTH];
    int unsigned depth;
    t_mode       lex;
    logic        semi_seen;
    logic [15:0] pos;
    logic        skipping;
    logic        stop_mode;

    t_out_beat   expected_verdicts [$];

    function automatic void clear_string();
        depth     = 0;
        lex       = M_NORMAL;
        semi_seen = 1'b0;
        pos       = '0;
        skipping  = 1'b0;
    endfunction

    // Byte seen as plain text; returns 1 when it decides the verdict.
    function automatic bit plain_byte(input logic [7:0] b, output t_verdict v,
                                      output logic [7:0] off);
        bit    is_close;
        bit    is_open;
        t_kind k;
        v        = V_OK;
        off      = '0;
        is_close = 1'b0;
        is_open  = 1'b0;
        k        = K_PAREN;
        case (b)
            CH_RPAREN: begin is_close = 1'b1; k = K_PAREN; end
            CH_RBRACK: begin is_close = 1'b1; k = K_BRACK; end
            CH_RBRACE: begin is_close = 1'b1; k = K_BRACE; end
            CH_LPAREN: begin is_open = 1'b1; k = K_PAREN; end
            CH_LBRACK: begin is_open = 1'b1; k = K_BRACK; end
            CH_LBRACE: begin is_open = 1'b1; k = K_BRACE; end
            default: ;
        endcase
        if (b == CH_DQUOTE) begin
            lex = M_DQ;
        end else if (b == CH_SQUOTE) begin
            lex = M_SQ;
        end else if (b == CH_COMMENT) begin
            lex = M_COMMENT;
        end else if (b == CH_SEMI) begin
            if (depth == 0) begin
                if (stop_mode) begin
                    v   = V_STOP;
                    off = b;
                    return 1'b1;
                end
                semi_seen = 1'b1;
            end
        end else if (is_close) begin
            if (depth == 0) begin
                v   = stop_mode ? V_STOP : V_UNMATCHED;
                off = b;
                return 1'b1;
            end
            depth--;
            if (kind_stack[depth] != k) begin
                v   = V_MISMATCH;
                off = OPENER[kind_stack[depth]];
                return 1'b1;
            end
        end else if (is_open) begin
            if (depth >= STACK_DEPTH) begin
                v   = V_TOO_DEEP;
                off = b;
                return 1'b1;
            end
            kind_stack[depth] = k;
            depth++;
        end
        return 1'b0;
    endfunction

    task automatic scan_beat(input t_in_beat ib);
        logic [7:0]  b;
        logic        fin;
        bit          hit;
        t_verdict    v;
        logic [7:0]  off;
        logic [15:0] at;
        t_out_beat   r;
        b   = ib.text_byte;
        fin = ib.final_byte;
        hit = 1'b0;
        v   = V_OK;
        off = '0;
        at  = pos;
        if (skipping) begin
            if (fin) clear_string();
            return;
        end
        case (lex)
            M_DQ: begin
                if (b == CH_BSLASH) lex = M_DQ_ESC;
                else if (b == CH_DQUOTE) lex = M_NORMAL;
            end
            M_DQ_ESC: begin
                lex = M_DQ;
            end
            M_SQ: begin
                if (b == CH_SQUOTE) lex = M_SQ_QUOTE;
            end
            M_SQ_QUOTE: begin
                if (b == CH_SQUOTE) begin
                    lex = M_SQ;
                end else begin
                    lex = M_NORMAL;
                    hit = plain_byte(b, v, off);
                end
            end
            M_COMMENT: begin
                if (b == CH_NEWLINE) lex = M_NORMAL;
            end
            default: begin
                lex = M_NORMAL;
                hit = plain_byte(b, v, off);
            end
        endcase
        // end of string: open quote outranks open brackets
        if (!hit && fin) begin
            hit = 1'b1;
            if (lex == M_DQ || lex == M_DQ_ESC) begin
                v   = V_UNCLOSED_QT;
                off = CH_DQUOTE;
            end else if (lex == M_SQ) begin
                v   = V_UNCLOSED_QT;
                off = CH_SQUOTE;
            end else if (depth > 0) begin
                v   = V_UNCLOSED_BR;
                off = OPENER[kind_stack[depth - 1]];
            end else begin
                v   = V_OK;
                off = '0;
            end
        end
        if (!hit) begin
            if (pos != 16'hFFFF) pos++;
            return;
        end
        r.verdict            = v;
        r.offending_byte     = off;
        r.byte_position      = at;
        r.top_semicolon_seen = semi_seen;
        expected_verdicts.push_back(r);
        o_pending++;
        if (fin) clear_string();
        else skipping = 1'b1;
    endtask

    task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
        if (o_fail_count < MAX_PRINTS)
            $display("mismatch on %s: want %0d got %0d at %0t", what, want, got, $time);
        o_fail_count++;
    endtask

    task automatic check_result(input t_out_beat got);
        t_out_beat want;
        if (expected_verdicts.size() == 0) begin
            report("unexpected verdict", '0, 16'(got.verdict));
            return;
        end
        want = expected_verdicts.pop_front();
        o_pending--;
        o_checked++;
        o_kinds_seen[got.verdict] = 1'b1;
        if (got.verdict !== want.verdict)
            report("verdict", 16'(want.verdict), 16'(got.verdict));
        if (got.offending_byte !== want.offending_byte)
            report("offending_byte", 16'(want.offending_byte), 16'(got.offending_byte));
        if (got.byte_position !== want.byte_position)
            report("byte_position", want.byte_position, got.byte_position);
        if (got.top_semicolon_seen !== want.top_semicolon_seen)
            report("top_semicolon_seen", 16'(want.top_semicolon_seen),
                   16'(got.top_semicolon_seen));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_string();
            stop_mode = 1'b0;
            expected_verdicts.delete();
            o_pending    = 0;
            o_kinds_seen = '0;
        end else begin
            if (i_cfg_we) stop_mode = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) check_result(i_out_beat);
            if (i_in_valid && !i_in_stall) scan_beat(i_in_beat);
        end
    end

endmodule

/* tb/sv/bracket_balance_checker_tb.sv */
`timescale 1ns / 1ps
// Top of the bracket balance checker testbench: stimulus, pacing and the final verdict.
module bracket_balance_checker_tb;
    import bbc_pkg::*;

    // Long receiver hold-off for the back-pressure phase, in cycles.
    localparam int HOLD_LEN     = 400;
    // Margin after the last predicted verdict before a config write or the
    // end, since a string may end with no verdict.
    localparam int DRAIN_CYCLES = 6;

    localparam logic [2:0][7:0] OPEN_CH  = {CH_LBRACE, CH_LBRACK, CH_LPAREN};
    localparam logic [2:0][7:0] CLOSE_CH = {CH_RBRACE, CH_RBRACK, CH_RPAREN};

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;

    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;

    int         fail_count;
    int         pending;
    int         checked;
    logic [7:0] kinds_seen;

    // Pacing knobs, percent of cycles; hold_req asks the receiver for one long hold-off.
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;

    t_in_beat beat_q [$];
    int       n_beats   = 0;
    int       n_strings = 0;

    bracket_balance_checker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bbc_verdict_monitor monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_beat   (out_beat),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_kinds_seen (kinds_seen)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop far past the slowest legal run (about a thousand beats, heavily paced).
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stall per cycle, or one long counted hold-off on request.
    // Exactly one nonblocking update of out_stall per clock step.
    initial begin : receiver
        int n;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                for (n = 0; n < HOLD_LEN; n++) @(posedge clk);
                hold_req = 1'b0;
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Text building: beats are queued first, then sent as one run.
    // ---------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b, input logic fin);
        t_in_beat t;
        t.text_byte  = b;
        t.final_byte = fin;
        beat_q.push_back(t);
        if (fin) n_strings++;
    endtask

    // One string; final flag goes on its last character.
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] any_but(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
        return c;
    endfunction

    // Mostly letters; now and then a full-range byte as noise.
    function automatic logic [7:0] plain_char();
        if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        return 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    // Random string of at least 'target' bytes. Most strings aim to be well formed
    // (brackets close in order, quotes terminate, a comment may stay open); a quarter
    // are broken on purpose and a tenth are pure noise.
    task automatic compose_text(input int target);
        logic [7:0] s [$];
        t_kind      open_k [$];
        t_kind      k;
        bit         broken;
        int         r;
        broken = ($urandom_range(0, 99) < 25);
        if ($urandom_range(0, 9) == 0) begin
            repeat (target) s.push_back(8'($urandom_range(0, 255)));
        end else begin
            while (s.size() < target) begin
                r = $urandom_range(0, 99);
                if (r < 18) begin
                    k = t_kind'($urandom_range(0, 2));
                    open_k.push_back(k);
                    s.push_back(OPEN_CH[k]);
                end else if (r < 34) begin
                    if (open_k.size() > 0 && (!broken || $urandom_range(0, 3) != 0))
                        s.push_back(CLOSE_CH[open_k.pop_back()]);
                    else if (broken)
                        s.push_back(CLOSE_CH[$urandom_range(0, 2)]);
                    else
                        s.push_back(plain_char());
                end else if (r < 42) begin
                    // double-quoted, with backslash escapes of any byte
                    s.push_back(CH_DQUOTE);
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            s.push_back(CH_BSLASH);
                            s.push_back(8'($urandom_range(0, 255)));
                        end else begin
                            s.push_back(any_but(CH_DQUOTE, CH_BSLASH));
                        end
                    end
                    if (!broken || $urandom_range(0, 1)) s.push_back(CH_DQUOTE);
                end else if (r < 50) begin
                    // single-quoted, doubled quote is a literal
                    s.push_back(CH_SQUOTE);
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            s.push_back(CH_SQUOTE);
                            s.push_back(CH_SQUOTE);
                        end else begin
                            s.push_back(any_but(CH_SQUOTE, CH_SQUOTE));
                        end
                    end
                    if (!broken || $urandom_range(0, 1)) s.push_back(CH_SQUOTE);
                end else if (r < 56) begin
                    s.push_back(CH_COMMENT);
                    repeat ($urandom_range(0, 4)) s.push_back(any_but(CH_NEWLINE, CH_NEWLINE));
                    if ($urandom_range(0, 4) != 0) s.push_back(CH_NEWLINE);
                end else if (r < 66) begin
                    s.push_back(CH_SEMI);
                end else begin
                    s.push_back(plain_char());
                end
            end
            if (!broken || $urandom_range(0, 1))
                while (open_k.size() > 0) s.push_back(CLOSE_CH[open_k.pop_back()]);
        end
        foreach (s[i]) add_byte(s[i], i == s.size() - 1);
    endtask

    // ---------------------------------------------------------------------
    // Input channel driving
    // ---------------------------------------------------------------------
    // One beat: optional idle cycles, then hold valid and payload until accepted.
    // Stall is read right after the edge, i.e. the value the edge sampled.
    task automatic send_beat(input t_in_beat b);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_beats++;
    endtask

    task automatic send_text();
        foreach (beat_q[i]) send_beat(beat_q[i]);
        beat_q.delete();
    endtask

    // Drop valid, wait for every predicted verdict, then let the pipe empty.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_stop_mode(input logic mode);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random strings under one stop_mode setting and one pacing profile.
    task automatic run_phase(input logic mode, input int idle, input int stall,
                             input int n_items, input int max_len, input bit with_hold);
        int start;
        write_stop_mode(mode);
        idle_pct  = idle;
        stall_pct = stall;
        hold_req  = with_hold;
        start     = n_beats;
        while (n_beats - start < n_items) begin
            compose_text($urandom_range(1, max_len));
            send_text();
        end
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, stop_mode at its reset value (full check)
        add_text("([{}]);");                      // ok with top-level semicolon
        add_text("\"\\");                         // backslash as last byte: quote open
        add_text("''");                           // quote closes on the last byte
        add_text("(\"");                          // open quote outranks open bracket
        add_byte(8'h00, 1'b1);                    // zero byte is plain text
        add_byte(CH_LBRACK, 1'b0);                // comment open at end is fine,
        add_byte(CH_COMMENT, 1'b1);               //   the bracket is not
        add_text(")");                            // unmatched close on the final byte
        add_text("(]");                           // mismatched pair
        add_byte(8'hFF, 1'b0);                    // unmatched close mid-string,
        add_text("}a");                           //   remainder discarded
        send_text();

        // Directed, stop mode
        write_stop_mode(1'b1);
        add_text("(;)]");                         // nested ';' ignored, top close stops
        add_text(";a");                           // top-level ';' stops, tail dropped
        add_text("b");                            // nothing to stop on: ok
        send_text();

        // Random phases: free flow, sender gaps, receiver stalls, both
        run_phase(1'b0, 0, 0, 210, 20, 1'b0);
        run_phase(1'b1, 72, 0, 210, 20, 1'b0);
        run_phase(1'b0, 0, 72, 210, 20, 1'b0);
        run_phase(1'b1, 22, 22, 210, 20, 1'b0);
        // Short strings against a long hold-off so the block backs up
        run_phase(1'b0, 0, 0, 110, 4, 1'b1);

        wait_idle();
        $display("Run: %0d beats in %0d strings, stop_mode 0 and 1, directed corner cases",
                 n_beats, n_strings);
        $display("and random text under gaps, stalls and a long hold-off; %0d verdicts, codes %b",
                 checked, kinds_seen);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
